[hw/rtl/kvl_pkg.sv]
// Package for the key-to-value lookup block.
// Holds field widths, parameter defaults and the item action codes.
// No dependencies.
package kvl_pkg;

  // Default table geometry
  localparam int TableDepthDef = 64;
  localparam int KeyBitsDef    = 16;

  // Fixed field widths of the stream items and the row register
  localparam int IdxW   = 6;
  localparam int FKeyW  = 16;
  localparam int ValW   = 16;
  localparam int RowsW  = 7;

  // Stream payload widths, tdata padded to whole bytes
  localparam int SDataRawW = IdxW + FKeyW + ValW + FKeyW;
  localparam int SDataW    = ((SDataRawW + 7) / 8) * 8;
  localparam int MDataW    = ValW;

  // Item kinds carried in s_axis_tuser
  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

endpackage

[hw/rtl/key_to_value_lookup_with_last_hit_cache.sv]
// Top level of the key-to-value lookup block with a last-hit cache.
// Depends on kvl_pkg and kvl_ram.
//
// Load beats whose entry_index is below TABLE_DEPTH write one key/value pair
// into the table RAM in the cycle they are accepted and clear the cache; other
// load beats are dropped. No load beat produces an output beat. A lookup whose
// key equals the last key found is answered from the cache: its result goes
// through ST_DONE into the output register. Any other lookup scans table entries
// 0 .. min(table_rows, TABLE_DEPTH)-1, one RAM read per cycle through the single
// read port of the table RAM; the highest matching entry wins and refreshes the
// cache. A miss returns value zero with the not-found flag (m_axis_tuser) set and
// leaves the cache alone. One item is in work at a time; the input is ready
// again in the cycle its result beat turns valid, and a finished result waits
// in the output register while the next item is taken. If that register still
// holds an untaken beat, the finished result and the input wait for it.
// table_rows is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module key_to_value_lookup_with_last_hit_cache #(
  parameter int TABLE_DEPTH = kvl_pkg::TableDepthDef,
  parameter int KEY_BITS    = kvl_pkg::KeyBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration: table_rows
  input  logic                       cfg_we_i,
  input  logic [kvl_pkg::RowsW-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: entry_index[5:0], entry_key[21:6], entry_value[37:22], query_key[53:38]
  input  logic [kvl_pkg::SDataW-1:0] s_axis_tdata,
  // tuser: action (0 load, 1 lookup)
  input  logic                       s_axis_tuser,
  // Output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata: chromosome_number[15:0]
  output logic [kvl_pkg::MDataW-1:0] m_axis_tdata,
  // tuser: not_found
  output logic                       m_axis_tuser
);

  import kvl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = KEY_BITS + ValW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_e;

  // Unpack the input beat
  logic [IdxW-1:0]     in_idx;
  logic [FKeyW-1:0]    in_ekey;
  logic [ValW-1:0]     in_eval;
  logic [FKeyW-1:0]    in_qkey;
  logic [KEY_BITS-1:0] ekey_w;
  logic [KEY_BITS-1:0] qkey_w;
  action_e             in_act;

  assign in_idx  = s_axis_tdata[IdxW-1:0];
  assign in_ekey = s_axis_tdata[IdxW+FKeyW-1:IdxW];
  assign in_eval = s_axis_tdata[IdxW+FKeyW+ValW-1:IdxW+FKeyW];
  assign in_qkey = s_axis_tdata[IdxW+2*FKeyW+ValW-1:IdxW+FKeyW+ValW];
  assign ekey_w  = KEY_BITS'(in_ekey);
  assign qkey_w  = KEY_BITS'(in_qkey);
  assign in_act  = action_e'(s_axis_tuser);

  // Registers
  state_e              state_q, state_d;
  logic [RowsW-1:0]    rows_q, rows_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       limit_q, limit_d;
  logic                pend_q, pend_d;
  logic                hit_q, hit_d;
  logic [ValW-1:0]     found_q, found_d;
  logic [KEY_BITS-1:0] qkey_q, qkey_d;
  logic [ValW-1:0]     res_val_q, res_val_d;
  logic                res_nf_q, res_nf_d;
  logic                cvalid_q, cvalid_d;
  logic [KEY_BITS-1:0] ckey_q, ckey_d;
  logic [ValW-1:0]     cval_q, cval_d;
  logic                out_valid_q, out_valid_d;
  logic [ValW-1:0]     out_data_q, out_data_d;
  logic                out_nf_q, out_nf_d;

  // Table RAM signals
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WW-1:0]       ram_wdata;
  logic                ram_re;
  logic [WW-1:0]       ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [ValW-1:0]     rd_val;
  logic                s_fire;
  logic                idx_ok;
  logic [CW-1:0]       row_limit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = 32'(in_idx) < 32'(TABLE_DEPTH);
  assign row_limit     = (32'(rows_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(rows_q);

  assign ram_waddr = AW'(in_idx);
  assign ram_wdata = {in_eval, ekey_w};
  assign rd_key    = ram_rdata[KEY_BITS-1:0];
  assign rd_val    = ram_rdata[WW-1:KEY_BITS];

  kvl_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    found_d     = found_q;
    qkey_d      = qkey_q;
    res_val_d   = res_val_q;
    res_nf_d    = res_nf_q;
    cvalid_d    = cvalid_q;
    ckey_d      = ckey_q;
    cval_d      = cval_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_nf_d    = out_nf_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    // Config write
    if (cfg_we_i) begin
      rows_d = cfg_wdata_i;
    end

    // Drop the output beat once taken
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (in_act)
            ACT_LOAD: begin
              if (idx_ok) begin
                ram_we   = 1'b1;
                cvalid_d = 1'b0;
              end
            end
            ACT_LOOKUP: begin
              qkey_d = qkey_w;
              if (cvalid_q && (qkey_w == ckey_q)) begin
                res_val_d = cval_q;
                res_nf_d  = 1'b0;
                state_d   = ST_DONE;
              end else begin
                cnt_d   = '0;
                limit_d = row_limit;
                hit_d   = 1'b0;
                pend_d  = 1'b0;
                state_d = ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SEARCH: begin
        // Compare the entry read last cycle; a later match overrides
        if (pend_q && (rd_key == qkey_q)) begin
          hit_d   = 1'b1;
          found_d = rd_val;
        end
        if (cnt_q != limit_q) begin
          ram_re = 1'b1;
          cnt_d  = cnt_q + CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            res_nf_d  = !hit_q;
            res_val_d = hit_q ? found_q : '0;
            if (hit_q) begin
              cvalid_d = 1'b1;
              ckey_d   = qkey_q;
              cval_d   = found_q;
            end
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_val_q;
          out_nf_d    = res_nf_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= '0;
      cnt_q       <= '0;
      limit_q     <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      cvalid_q    <= 1'b0;
      ckey_q      <= '0;
      cval_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      cnt_q       <= cnt_d;
      limit_q     <= limit_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      cvalid_q    <= cvalid_d;
      ckey_q      <= ckey_d;
      cval_q      <= cval_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    found_q    <= found_d;
    qkey_q     <= qkey_d;
    res_val_q  <= res_val_d;
    res_nf_q   <= res_nf_d;
    out_data_q <= out_data_d;
    out_nf_q   <= out_nf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_nf_q;

endmodule

[hw/rtl/kvl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the lookup table storage. No package dependencies.
module kvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
